[src/body_to_world_velocity_rotation_core_macros.svh]
// assertion helpers used by the sequencer
`ifndef BODY_TO_WORLD_VELOCITY_ROTATION_CORE_MACROS_SVH
`define BODY_TO_WORLD_VELOCITY_ROTATION_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is asserted
`define BWVR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also checked during reset
`define BWVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BWVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define BWVR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/bwvr_pkg.sv]
package bwvr_pkg;

    // item modes
    localparam logic [1:0] MODE_ATT  = 2'd0;
    localparam logic [1:0] MODE_VEL  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // datapath widths
    localparam int TAB_IDX_W = 5;
    localparam int CORDIC_W  = 37;
    localparam int ZW        = 33;
    localparam int ACC_W     = 50;
    localparam int NUM_W     = 34;

    // fixed point constants
    localparam logic signed [NUM_W-1:0]    ONE_Q30   = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] KINV_Q30  = 37'sd652032874;
    localparam logic signed [ZW-1:0]       Z_QUARTER = 33'sh0_4000_0000;
    localparam logic signed [ZW-1:0]       Z_HALF    = 33'sh0_8000_0000;
    localparam logic signed [ACC_W-1:0]    RND_HALF  = 50'sd536870912;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] cmd_lin_x;
        logic signed [15:0] cmd_lin_y;
        logic signed [15:0] cmd_lin_z;
        logic signed [15:0] cmd_yaw_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] world_vel_x;
        logic signed [15:0] world_vel_y;
        logic signed [15:0] world_vel_z;
        logic signed [15:0] yaw_rate_out;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ATT_MUL,
        ST_VEC_LOAD,
        ST_VEC_ITER,
        ST_VEC_DONE,
        ST_ROT_LOAD,
        ST_ROT_ITER,
        ST_ROT_MUL,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MUL_W_QZ,
        MUL_X_Y,
        MUL_Y_Y,
        MUL_Z_Z,
        MUL_BX_C,
        MUL_BY_S,
        MUL_BX_S,
        MUL_BY_C
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     capture_quat;
        logic     write_vel;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     save_num;
        logic     load_vec;
        logic     load_rot;
        logic     cordic_step;
        logic     write_heading;
        logic     save_res_x;
        logic     load_out;
    } dp_cmd_t;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic [31:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[src/bwvr_dp.sv]
module bwvr_dp
    import bwvr_pkg::*;
#(
    parameter int STEP_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_item_t          in_data,
    input  dp_cmd_t           cmd,
    input  logic [STEP_W-1:0] step_idx,
    output out_item_t         out_data
);

    // negate with saturation of the most negative value
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == -16'sd32768)
        begin
            r = 16'sd32767;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

    // round a q30 product sum to the output scale and saturate
    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-31:0] r;
        logic signed [15:0] s;
        t = v + RND_HALF;
        r = t[ACC_W-1:30];
        if (r > 20'sd32767)
        begin
            s = 16'sd32767;
        end
        else if (r < -20'sd32768)
        begin
            s = -16'sd32768;
        end
        else
        begin
            s = r[15:0];
        end
        return s;
    endfunction

    // architectural state
    logic signed [15:0] body_x_reg, body_y_reg, body_z_reg, held_rate_reg;
    logic [15:0]        heading_reg;

    // working registers
    logic signed [15:0]         q_w_reg, q_x_reg, q_y_reg, q_z_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [ZW-1:0]       cz_reg, cz_next;
    logic                       vec_mode_reg, vec_mode_next;
    logic                       flip_reg, flip_next;
    logic                       zero_reg, zero_next;
    logic signed [15:0]         res_x_reg;
    out_item_t                  out_reg;
    logic [15:0]                heading_next;

    // multiplier operand select
    logic signed [15:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [47:0]      prod;
    logic signed [ACC_W-1:0] prod_ext, term;
    logic                    rot_sel, negate;

    always_comb
    begin
        rot_sel = 1'b1;
        case (cmd.mul_sel)
            MUL_W_QZ:
            begin
                mul_a = q_w_reg;
                mul_b = {{16{q_z_reg[15]}}, q_z_reg};
                rot_sel = 1'b0;
            end
            MUL_X_Y:
            begin
                mul_a = q_x_reg;
                mul_b = {{16{q_y_reg[15]}}, q_y_reg};
                rot_sel = 1'b0;
            end
            MUL_Y_Y:
            begin
                mul_a = q_y_reg;
                mul_b = {{16{q_y_reg[15]}}, q_y_reg};
                rot_sel = 1'b0;
            end
            MUL_Z_Z:
            begin
                mul_a = q_z_reg;
                mul_b = {{16{q_z_reg[15]}}, q_z_reg};
                rot_sel = 1'b0;
            end
            MUL_BX_C:
            begin
                mul_a = body_x_reg;
                mul_b = cx_reg[31:0];
            end
            MUL_BY_S:
            begin
                mul_a = body_y_reg;
                mul_b = cy_reg[31:0];
            end
            MUL_BX_S:
            begin
                mul_a = body_x_reg;
                mul_b = cy_reg[31:0];
            end
            MUL_BY_C:
            begin
                mul_a = body_y_reg;
                mul_b = cx_reg[31:0];
            end
            default:
            begin
                mul_a = q_w_reg;
                mul_b = cx_reg[31:0];
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-48){prod[47]}}, prod};
    // folded angle negates sine and cosine, applied as a sign on the product
    assign negate   = (cmd.acc_op == ACC_SUB) ^ (rot_sel & flip_reg);
    assign term     = negate ? -prod_ext : prod_ext;

    // accumulator
    always_comb
    begin
        case (cmd.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_LOAD: acc_next = term;
            ACC_ADD:  acc_next = acc_reg + term;
            ACC_SUB:  acc_next = acc_reg + term;
            default:  acc_next = acc_reg;
        endcase
    end

    // atan2 operands and vectoring start
    logic signed [NUM_W-1:0]    den;
    logic signed [CORDIC_W-1:0] den_ext, num_ext;
    assign den     = ONE_Q30 - {acc_reg[32:0], 1'b0};
    assign den_ext = {{(CORDIC_W-NUM_W){den[NUM_W-1]}}, den};
    assign num_ext = {{(CORDIC_W-NUM_W){num_reg[NUM_W-1]}}, num_reg};

    // rotation start: heading widened to a 32-bit angle
    logic signed [ZW-1:0] z_head;
    assign z_head = {heading_reg[15], heading_reg, 16'h0000};

    // one shared cordic step
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ZW-1:0]       atan_ext;
    logic                       up;
    assign xs       = cx_reg >>> step_idx;
    assign ys       = cy_reg >>> step_idx;
    assign atan_ext = {1'b0, atan_entry(TAB_IDX_W'(step_idx))};
    assign up       = vec_mode_reg ? cy_reg[CORDIC_W-1] : ~cz_reg[ZW-1];

    always_comb
    begin
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        vec_mode_next = vec_mode_reg;
        flip_next     = flip_reg;
        zero_next     = zero_reg;
        if (cmd.load_vec)
        begin
            vec_mode_next = 1'b1;
            zero_next     = (num_reg == '0) && (den == '0);
            if (den[NUM_W-1])
            begin
                cx_next = -den_ext;
                cy_next = -num_ext;
                cz_next = Z_HALF;
            end
            else
            begin
                cx_next = den_ext;
                cy_next = num_ext;
                cz_next = '0;
            end
        end
        else if (cmd.load_rot)
        begin
            vec_mode_next = 1'b0;
            cx_next       = KINV_Q30;
            cy_next       = '0;
            if (z_head > Z_QUARTER)
            begin
                cz_next   = z_head - Z_HALF;
                flip_next = 1'b1;
            end
            else if (z_head < -Z_QUARTER)
            begin
                cz_next   = z_head + Z_HALF;
                flip_next = 1'b1;
            end
            else
            begin
                cz_next   = z_head;
                flip_next = 1'b0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (up)
            begin
                cx_next = cx_reg - ys;
                cy_next = cy_reg + xs;
                cz_next = cz_reg - atan_ext;
            end
            else
            begin
                cx_next = cx_reg + ys;
                cy_next = cy_reg - xs;
                cz_next = cz_reg + atan_ext;
            end
        end
    end

    // yaw rounded to 16 bits, heading is its negation (zero when both atan2 operands are zero)
    logic [31:0] yaw_sum;
    assign yaw_sum      = cz_reg[31:0] + 32'h0000_8000;
    assign heading_next = zero_reg ? 16'h0000 : 16'h0000 - yaw_sum[31:16];

    // architectural state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_x_reg    <= '0;
            body_y_reg    <= '0;
            body_z_reg    <= '0;
            held_rate_reg <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            if (cmd.write_vel)
            begin
                body_x_reg    <= neg_sat16(in_data.cmd_lin_y);
                body_y_reg    <= in_data.cmd_lin_x;
                body_z_reg    <= neg_sat16(in_data.cmd_lin_z);
                held_rate_reg <= in_data.cmd_yaw_rate;
            end
            if (cmd.write_heading)
            begin
                heading_reg <= heading_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture_quat)
        begin
            q_w_reg <= in_data.quat_w;
            q_x_reg <= in_data.quat_x;
            q_y_reg <= in_data.quat_y;
            q_z_reg <= in_data.quat_z;
        end
        if (cmd.save_num)
        begin
            num_reg <= {acc_reg[32:0], 1'b0};
        end
        if (cmd.save_res_x)
        begin
            res_x_reg <= round_sat(acc_reg);
        end
        if (cmd.load_out)
        begin
            out_reg.world_vel_x  <= res_x_reg;
            out_reg.world_vel_y  <= round_sat(acc_reg);
            out_reg.world_vel_z  <= body_z_reg;
            out_reg.yaw_rate_out <= held_rate_reg;
        end
        acc_reg      <= acc_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        vec_mode_reg <= vec_mode_next;
        flip_reg     <= flip_next;
        zero_reg     <= zero_next;
    end

    assign out_data = out_reg;

endmodule

[src/bwvr_ctrl.sv]
`include "body_to_world_velocity_rotation_core_macros.svh"

module bwvr_ctrl
    import bwvr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int STEP_W       = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output dp_cmd_t           cmd,
    output logic [STEP_W-1:0] step_idx
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_en_reg;

    // state, counter, output flag and output enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                out_en_reg <= cfg_data;
            end
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    case (in_mode)
                        MODE_ATT:
                        begin
                            cmd.capture_quat = 1'b1;
                            state_next       = ST_ATT_MUL;
                        end
                        MODE_VEL:
                        begin
                            cmd.write_vel = 1'b1;
                        end
                        MODE_TICK:
                        begin
                            if (out_en_reg)
                            begin
                                state_next = ST_ROT_LOAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ATT_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        cmd.mul_sel = MUL_W_QZ;
                        cmd.acc_op  = ACC_LOAD;
                    end
                    2'd1:
                    begin
                        cmd.mul_sel = MUL_X_Y;
                        cmd.acc_op  = ACC_ADD;
                    end
                    2'd2:
                    begin
                        cmd.save_num = 1'b1;
                        cmd.mul_sel  = MUL_Y_Y;
                        cmd.acc_op   = ACC_LOAD;
                    end
                    default:
                    begin
                        cmd.mul_sel = MUL_Z_Z;
                        cmd.acc_op  = ACC_ADD;
                        cnt_next    = '0;
                        state_next  = ST_VEC_LOAD;
                    end
                endcase
            end
            ST_VEC_LOAD:
            begin
                cmd.load_vec = 1'b1;
                state_next   = ST_VEC_ITER;
            end
            ST_VEC_ITER:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_VEC_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_VEC_DONE:
            begin
                cmd.write_heading = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_ROT_LOAD:
            begin
                cmd.load_rot = 1'b1;
                state_next   = ST_ROT_ITER;
            end
            ST_ROT_ITER:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROT_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROT_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        cmd.mul_sel = MUL_BX_C;
                        cmd.acc_op  = ACC_LOAD;
                    end
                    2'd1:
                    begin
                        cmd.mul_sel = MUL_BY_S;
                        cmd.acc_op  = ACC_SUB;
                    end
                    2'd2:
                    begin
                        cmd.save_res_x = 1'b1;
                        cmd.mul_sel    = MUL_BX_S;
                        cmd.acc_op     = ACC_LOAD;
                    end
                    default:
                    begin
                        cmd.mul_sel = MUL_BY_C;
                        cmd.acc_op  = ACC_ADD;
                        cnt_next    = '0;
                        state_next  = ST_OUT;
                    end
                endcase
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register flag
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign step_idx  = cnt_reg;

    // checks
    `BWVR_ASSERT(a_att_start, clk, rst_n, (in_valid && in_ready && in_mode == MODE_ATT) |=> (state_reg == ST_ATT_MUL && cnt_reg == '0), "attitude request did not start the multiply phase")
    `BWVR_ASSERT(a_vel_done, clk, rst_n, (in_valid && in_ready && in_mode == MODE_VEL) |=> (state_reg == ST_IDLE), "velocity request did not complete in one cycle")
    `BWVR_ASSERT(a_tick_off, clk, rst_n, (in_valid && in_ready && in_mode == MODE_TICK && !out_en_reg) |=> (state_reg == ST_IDLE), "tick with output disabled started work")
    `BWVR_ASSERT_ALWAYS(a_out_src, clk, $rose(out_valid_reg) |-> $past(state_reg == ST_OUT), "result appeared outside the output state")
    `BWVR_ASSERT(a_iter_cnt, clk, rst_n, (state_reg == ST_VEC_ITER || state_reg == ST_ROT_ITER) |-> (cnt_reg <= LAST_STEP), "cordic step count ran past the last step")

endmodule

[src/body_to_world_velocity_rotation_core.sv]
// Body to world velocity rotation. Attitude requests (mode 0) turn a Q1.15 quaternion into
// the negated yaw, atan2(2(wz+xy), 1-2(y^2+z^2)), with a CORDIC vectoring pass. Velocity
// requests (mode 1) store the remapped Q8.8 command as they are taken. Tick requests
// (mode 2), while output_enable is set, get sine and cosine of the heading from a CORDIC
// rotation pass and apply them through a multiply-accumulate; the block is ready for the
// next request in the same cycle that out_valid rises. The result is held in an output
// register, so the next request is taken while it waits; a later tick stalls in its
// output state only while that register is still full. The datapath uses the single
// shared CORDIC unit, one iteration per cycle, and the one 16x32 multiplier that forms
// each product in its own cycle. Ticks with output disabled and mode 3 requests are
// dropped without a result.
module body_to_world_velocity_rotation_core
    import bwvr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_data
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    dp_cmd_t           cmd;
    logic [STEP_W-1:0] step_idx;

    // sequencer
    bwvr_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .STEP_W      (STEP_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (in_data.mode),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .step_idx (step_idx)
    );

    // arithmetic and state
    bwvr_dp #(
        .STEP_W(STEP_W)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .step_idx(step_idx),
        .out_data(out_data)
    );

endmodule
